### sv/rdmst_pkg.sv
// package: types, defaults and sequencer states for the reverse-delete tree weight core
`default_nettype none
package rdmst_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int MaxEdgesDef    = 256;
  localparam int VertexW        = 6;
  localparam int WeightW        = 32;
  localparam int SumW           = 40;
  localparam int CfgW           = 7;

  typedef struct packed {
    logic [VertexW-1:0]        edge_from;
    logic [VertexW-1:0]        edge_to;
    logic signed [WeightW-1:0] edge_weight;
    logic                      is_last;
  } edge_req_t;

  typedef struct packed {
    logic signed [SumW-1:0] tree_weight;
    logic                   edges_dropped;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_FIND,
    S_CLR,
    S_WALK,
    S_POP,
    S_ULOAD,
    S_CHECK,
    S_SUM,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### sv/reverse_delete_mst_weight_core.sv
// reverse-delete minimum spanning tree weight core
//
// Edges arrive as requests on req_i, one per cycle, accepted when start is
// high and busy is low. Each request is stored in the edge ram, or dropped
// and flagged when an endpoint is at or above the vertex count or the store
// is full. A request with is_last set starts the computation and busy rises.
// The sequencer sweeps the edge ram and the mark ram through their read
// ports: one sweep marks out-of-range edges, then per candidate one sweep
// finds the heaviest unprocessed edge, a clearing pass over the vertices resets the
// visited ram, and one sweep per reached vertex walks the graph depth first
// (vertex stack in a further ram), and a final sweep adds the kept weights.
// The result is valid on result_o while done_o is high for a single cycle,
// then the store is empty and busy falls. There is no backpressure on the
// result. The user must write vertex_count through cfg_we_i only while
// idle; the block itself does not enforce it. Reset clears the edge count
// and the drop flag; vertex_count returns to 1.
`default_nettype none
module reverse_delete_mst_weight_core
  import rdmst_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire edge_req_t       req_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  output logic                 done_o,
  output result_t              result_o
);

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > CfgW) ? NW : CfgW;
  localparam int RW = 2 * VertexW + WeightW;

  state_e state_q, state_d;

  logic [CfgW-1:0]         vc_q, vc_d;
  logic [EW:0]             cnt_q, cnt_d;
  logic                    drop_q, drop_d;
  logic [CW-1:0]           vcnt_q, vcnt_d;
  logic [CW-1:0]           clr_q, clr_d;
  logic [VW:0]             top_q, top_d;
  logic [VertexW-1:0]      u_q, u_d;
  logic [EW:0]             idx_q, idx_d;
  logic                    pv_q, pv_d;
  logic [EW-1:0]           pidx_q, pidx_d;
  logic                    c2_q, c2_d;
  logic [VertexW-1:0]      o2_q, o2_d;
  logic                    hit_q, hit_d;
  logic [VertexW-1:0]      hv_q, hv_d;
  logic                    found_q, found_d;
  logic [EW-1:0]           best_q, best_d;
  logic signed [WeightW-1:0] bestw_q, bestw_d;
  logic signed [SumW-1:0]  sum_q, sum_d;

  logic [CW-1:0]    vc_ext, n_eff;
  logic             issue, sweep_done, in_ok, accept;
  logic             e_we;
  logic [RW-1:0]    e_wdata, e_rdata;
  logic [VertexW-1:0] ra, rb, other;
  logic signed [WeightW-1:0] rw;
  logic             adj;
  logic             s_we;
  logic [VW:0]      top_m1;
  logic             m_we, m_proc_w, m_rem_w;
  logic [EW-1:0]    m_waddr;
  logic [1:0]       m_rdata;
  logic             r_proc, r_rem;
  logic             v_we, v_wdata, v_rdata, vis_hit;
  logic [VW-1:0]    v_waddr;

  assign vc_ext = CW'(vc_q);
  always_comb begin
    if (vc_ext == '0) begin
      n_eff = CW'(1);
    end else if (vc_ext > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = vc_ext;
    end
  end

  assign accept = start && !busy;
  assign in_ok  = (CW'(req_i.edge_from) < n_eff) && (CW'(req_i.edge_to) < n_eff)
                  && (cnt_q < (EW+1)'(MAX_EDGES));
  assign e_we    = accept && in_ok;
  assign e_wdata = {req_i.edge_from, req_i.edge_to, req_i.edge_weight};
  assign {ra, rb, rw} = e_rdata;

  rdmst_ram #(.Width(RW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (cnt_q[EW-1:0]),
    .wdata_i (e_wdata),
    .raddr_i (idx_q[EW-1:0]),
    .rdata_o (e_rdata)
  );

  // per-edge processed and removed marks
  rdmst_ram #(.Width(2), .Depth(MAX_EDGES)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i ({m_proc_w, m_rem_w}),
    .raddr_i (idx_q[EW-1:0]),
    .rdata_o (m_rdata)
  );
  assign {r_proc, r_rem} = m_rdata;

  // visited vertices of the current walk
  rdmst_ram #(.Width(1), .Depth(MAX_VERTICES)) u_visit_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (VW'(other)),
    .rdata_o (v_rdata)
  );
  assign vis_hit = v_rdata || (hit_q && (hv_q == o2_q));

  logic [VertexW-1:0] s_rdata;
  assign top_m1 = top_q - 1'b1;

  rdmst_ram #(.Width(VertexW), .Depth(MAX_VERTICES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (top_q[VW-1:0]),
    .wdata_i (o2_q),
    .raddr_i (top_m1[VW-1:0]),
    .rdata_o (s_rdata)
  );

  assign issue      = (idx_q < cnt_q);
  assign sweep_done = !issue && !pv_q && !c2_q;

  always_comb begin
    if (ra == u_q) begin
      other = rb;
      adj   = 1'b1;
    end else if (rb == u_q) begin
      other = ra;
      adj   = 1'b1;
    end else begin
      other = ra;
      adj   = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && req_i.is_last) state_d = S_INIT;
      S_INIT:  if (sweep_done) state_d = S_FIND;
      S_FIND:  if (sweep_done) state_d = found_q ? S_CLR : S_SUM;
      S_CLR:   if (clr_q == n_eff - CW'(1)) state_d = S_WALK;
      S_WALK:  if (sweep_done) state_d = S_POP;
      S_POP:   state_d = (top_q == '0) ? S_CHECK : S_ULOAD;
      S_ULOAD: state_d = S_WALK;
      S_CHECK: state_d = S_FIND;
      S_SUM:   if (sweep_done) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    vc_d     = cfg_we_i ? cfg_wdata_i : vc_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    vcnt_d   = vcnt_q;
    clr_d    = clr_q;
    top_d    = top_q;
    u_d      = u_q;
    idx_d    = idx_q;
    pv_d     = 1'b0;
    pidx_d   = idx_q[EW-1:0];
    c2_d     = 1'b0;
    o2_d     = other;
    hit_d    = 1'b0;
    hv_d     = o2_q;
    found_d  = found_q;
    best_d   = best_q;
    bestw_d  = bestw_q;
    sum_d    = sum_q;
    s_we     = 1'b0;
    m_we     = 1'b0;
    m_waddr  = pidx_q;
    m_proc_w = 1'b0;
    m_rem_w  = 1'b0;
    v_we     = 1'b0;
    v_waddr  = VW'(o2_q);
    v_wdata  = 1'b1;

    if (state_q == S_INIT || state_q == S_FIND || state_q == S_WALK
        || state_q == S_SUM) begin
      pv_d = issue;
      if (issue) idx_d = idx_q + 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_ok) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          idx_d = '0;
        end
      end
      S_INIT: begin
        if (pv_q) begin
          m_we    = 1'b1;
          m_rem_w = (CW'(ra) >= n_eff) || (CW'(rb) >= n_eff);
        end
        if (sweep_done) begin
          idx_d   = '0;
          found_d = 1'b0;
        end
      end
      S_FIND: begin
        if (pv_q && !r_proc && !r_rem && (!found_q || rw > bestw_q)) begin
          found_d = 1'b1;
          best_d  = pidx_q;
          bestw_d = rw;
        end
        if (sweep_done) begin
          idx_d = '0;
          if (found_q) begin
            m_we     = 1'b1;
            m_waddr  = best_q;
            m_proc_w = 1'b1;
            m_rem_w  = 1'b1;
            clr_d    = '0;
            vcnt_d   = CW'(1);
            top_d    = '0;
            u_d      = '0;
          end else begin
            sum_d = '0;
          end
        end
      end
      S_CLR: begin
        v_we    = 1'b1;
        v_waddr = VW'(clr_q);
        v_wdata = (clr_q == '0);
        clr_d   = clr_q + 1'b1;
      end
      S_WALK: begin
        c2_d = pv_q && !r_rem && adj && (CW'(other) < n_eff);
        if (c2_q && !vis_hit) begin
          v_we   = 1'b1;
          vcnt_d = vcnt_q + 1'b1;
          s_we   = 1'b1;
          top_d  = top_q + 1'b1;
          hit_d  = 1'b1;
        end
      end
      S_POP: begin
        if (top_q != '0) top_d = top_m1;
      end
      S_ULOAD: begin
        u_d   = s_rdata;
        idx_d = '0;
      end
      S_CHECK: begin
        if (vcnt_q != n_eff) begin
          m_we     = 1'b1;
          m_waddr  = best_q;
          m_proc_w = 1'b1;
        end
        idx_d   = '0;
        found_d = 1'b0;
      end
      S_SUM: begin
        if (pv_q && !r_rem) sum_d = sum_q + SumW'(rw);
      end
      S_DONE: begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end
      default: ;
    endcase
  end

  // outputs
  assign busy                   = (state_q != S_IDLE);
  assign done_o                 = (state_q == S_DONE);
  assign result_o.tree_weight   = sum_q;
  assign result_o.edges_dropped = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vc_q    <= CfgW'(1);
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      top_q   <= '0;
      idx_q   <= '0;
      pv_q    <= 1'b0;
      c2_q    <= 1'b0;
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vc_q    <= vc_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      top_q   <= top_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
      c2_q    <= c2_d;
      hit_q   <= hit_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vcnt_q  <= vcnt_d;
    clr_q   <= clr_d;
    u_q     <= u_d;
    pidx_q  <= pidx_d;
    o2_q    <= o2_d;
    hv_q    <= hv_d;
    best_q  <= best_d;
    bestw_q <= bestw_d;
    sum_q   <= sum_d;
  end

endmodule
`default_nettype wire

### sv/rdmst_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rdmst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
